/* hdl/vlids_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlids_pkg: shared types for the value list
// Beat structs for both channels, operation codes and the control word that
// is broadcast along the chain of list cells.
// ----------------------------------------------------------------------------
package vlids_pkg;

    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SORT   = 2'd2,
        MODE_DUMP   = 2'd3
    } mode_t;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_DROPPED = 1'b1;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [VAL_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] entry;
        logic                    last;
    } out_beat_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_ROTATE = 2'd2,
        CELL_SORT   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic                    drop;
        logic                    phase;
        logic signed [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

/* hdl/vlids_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlids_cell: one list position
// Holds one entry; loads, rotates towards the head or compare-swaps with its
// neighbour under the broadcast control word.
// ----------------------------------------------------------------------------
module vlids_cell
    import vlids_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int INDEX = 0
) (
    input  logic                          clk,
    input  cell_ctrl_t                    ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic signed [VAL_W-1:0]       left_val,
    input  logic signed [VAL_W-1:0]       right_val,
    input  logic signed [VAL_W-1:0]       head_val,
    input  logic                          left_swap,
    output logic signed [VAL_W-1:0]       val,
    output logic                          swap
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(INDEX + 1);
    localparam logic             PARITY   = 1'(INDEX % 2);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    is_lower;

    // lower cell of an active pair swaps when the upper one is greater
    assign is_lower = (ctrl.phase == PARITY) && (POS_NEXT < count);
    assign swap     = is_lower && (right_val > val_reg);
    assign val      = val_reg;

    always_comb
    begin
        val_next = val_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                val_next = val_reg;
            end
            CELL_LOAD:
            begin
                if (POS == count)
                    val_next = ctrl.value;
            end
            CELL_ROTATE:
            begin
                if (POS_NEXT < count)
                    val_next = right_val;
                else if ((POS_NEXT == count) && !ctrl.drop)
                    val_next = head_val;
            end
            CELL_SORT:
            begin
                if (swap)
                    val_next = right_val;
                else if (left_swap)
                    val_next = left_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* hdl/value_list_insert_delete_sort.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_list_insert_delete_sort: insert, delete, dump and descending sort
// A chain of DEPTH cells holds the bounded list; cell 0 is the head.
// ----------------------------------------------------------------------------
// An insert with room finishes in its accepting cycle; a full insert moves to
// the full state and latches its drop beat there once the output register is
// free. Delete, dump and sort keep the input stalled while they walk the list
// (not at all with nothing to walk), so an item is through before the next is
// taken; dump beats follow one a cycle, held back only by output stall.
// Reset clears the count and all control state; cell contents stay undefined.
module value_list_insert_delete_sort
    import vlids_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ROTATE = 4'b0010,
        S_SORT   = 4'b0100,
        S_FULL   = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic [CNT_W-1:0]        step_reg, step_next;
    logic                    found_reg, found_next;
    mode_t                   mode_reg, mode_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    out_valid_reg, out_valid_next;
    out_beat_t               out_data_reg, out_data_next;

    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] cell_val  [DEPTH];
    logic                    cell_swap [DEPTH];
    logic signed [VAL_W-1:0] head;
    logic                    out_free;
    logic                    final_step;

    assign head       = cell_val[0];
    assign out_free   = !out_valid_reg || !out_stall;
    assign final_step = (step_reg == (len_reg - ONE_C));

    // ------------------------------------------------------------------
    // Cell chain: each cell sees both neighbours and the head
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_v;
        logic signed [VAL_W-1:0] right_v;
        logic                    left_s;

        if (i == 0)
        begin : g_first
            assign left_v = cell_val[i];
            assign left_s = 1'b0;
        end
        else
        begin : g_mid
            assign left_v = cell_val[i-1];
            assign left_s = cell_swap[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_v = cell_val[i];
        end
        else
        begin : g_body
            assign right_v = cell_val[i+1];
        end

        vlids_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .left_val  (left_v),
            .right_val (right_v),
            .head_val  (head),
            .left_swap (left_s),
            .val       (cell_val[i]),
            .swap      (cell_swap[i])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // Delete: rotate the live ring once round; the first head that matches
    //   is not fed back to the tail, which closes the gap with order kept.
    // Dump: same rotation, copying the head into the output register.
    // Sort: one odd or even compare-swap pass per cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        mode_next      = mode_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        ctrl.op    = CELL_HOLD;
        ctrl.drop  = 1'b0;
        ctrl.phase = step_reg[0];
        ctrl.value = in_data.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode_t'(in_data.mode);
                    value_next = in_data.value;
                    len_next   = count_reg;
                    step_next  = '0;
                    found_next = 1'b0;
                    unique case (mode_t'(in_data.mode))
                        MODE_INSERT:
                        begin
                            if (count_reg == DEPTH_C)
                                state_next = S_FULL;
                            else
                            begin
                                ctrl.op    = CELL_LOAD;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        MODE_DELETE, MODE_DUMP:
                        begin
                            if (count_reg != '0)
                                state_next = S_ROTATE;
                        end
                        MODE_SORT:
                        begin
                            if (count_reg > ONE_C)
                                state_next = S_SORT;
                        end
                    endcase
                end
            end
            S_ROTATE:
            begin
                // a dump step waits for room in the output register
                if ((mode_reg != MODE_DUMP) || out_free)
                begin
                    ctrl.op   = CELL_ROTATE;
                    ctrl.drop = (mode_reg == MODE_DELETE) && !found_reg
                                && (head == value_reg);
                    if (ctrl.drop)
                    begin
                        count_next = count_reg - ONE_C;
                        found_next = 1'b1;
                    end
                    if (mode_reg == MODE_DUMP)
                    begin
                        out_valid_next      = 1'b1;
                        out_data_next.kind  = KIND_ENTRY;
                        out_data_next.entry = head;
                        out_data_next.last  = final_step;
                    end
                    step_next = step_reg + ONE_C;
                    if (final_step)
                        state_next = S_IDLE;
                end
            end
            S_SORT:
            begin
                ctrl.op   = CELL_SORT;
                step_next = step_reg + ONE_C;
                if (final_step)
                    state_next = S_IDLE;
            end
            S_FULL:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_data_next.kind  = KIND_DROPPED;
                    out_data_next.entry = value_reg;
                    out_data_next.last  = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            len_reg       <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            mode_reg      <= MODE_INSERT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: hold the beat and the latched operand without reset
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("list count beyond depth");

    a_sort_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SORT |=> count_reg == $past(count_reg))
        else $error("sort changed the list length");

    a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROTATE && mode_reg == MODE_DUMP)
        |=> count_reg == $past(count_reg))
        else $error("dump changed the list length");

    a_single_delete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROTATE && found_reg) |=> count_reg == $past(count_reg))
        else $error("delete removed more than one entry");

    a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.kind == KIND_DROPPED) |-> out_data_reg.last)
        else $error("dropped insert beat not marked last");

endmodule
